[sv/ir_pulse_distance_decoder_top_defines.svh]
// Assertion macros used by the top module of the infrared decoder.
`ifndef IR_PULSE_DISTANCE_DECODER_TOP_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irpd same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irpd next-cycle check failed");

`endif

[sv/irpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

    localparam int TIME_BITS  = 16;
    localparam int CODE_BITS  = 32;
    localparam int COUNT_BITS = 8;
    localparam int MID_DEPTH  = 2;
    localparam int RES_DEPTH  = 2;

    localparam logic [TIME_BITS-1:0] ZERO_FLOOR_RESET = TIME_BITS'(12);
    localparam logic [TIME_BITS-1:0] ONE_FLOOR_RESET  = TIME_BITS'(28);
    localparam logic [TIME_BITS-1:0] ONE_LIMIT_RESET  = TIME_BITS'(55);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_FRAME = COUNT_BITS'(CODE_BITS);
    localparam logic [CODE_BITS-1:0]  BAD_CODE    = '1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ZERO_FLOOR = 2'd0,
        REG_ONE_FLOOR  = 2'd1,
        REG_ONE_LIMIT  = 2'd2
    } reg_index_t;

    // Symbol decided for one gap.
    typedef enum logic [1:0] {
        SYM_NONE = 2'd0,
        SYM_ZERO = 2'd1,
        SYM_ONE  = 2'd2
    } sym_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] edge_time;
        logic                 frame_end;
    } in_item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]  code_word;
        logic                  code_valid;
        logic [COUNT_BITS-1:0] bits_seen;
    } out_item_t;

    typedef struct packed {
        sym_t sym;
        logic last;
    } mid_entry_t;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           index;
        logic [TIME_BITS-1:0] data;
    } cfg_write_t;

endpackage

`default_nettype wire

[sv/irpd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// Small register queue. DEPTH must be at least two; the queue does not enforce this.
module irpd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[sv/irpd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// Holds the thresholds and the previous timestamp and turns each edge into a symbol.
module irpd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire irpd_pkg::cfg_write_t cfg,
    input  wire logic                 accept,
    input  wire irpd_pkg::in_item_t   item,
    output irpd_pkg::mid_entry_t      entry
);

    logic [irpd_pkg::TIME_BITS-1:0] zero_floor_reg;
    logic [irpd_pkg::TIME_BITS-1:0] one_floor_reg;
    logic [irpd_pkg::TIME_BITS-1:0] one_limit_reg;
    logic [irpd_pkg::TIME_BITS-1:0] prior_time_reg;
    logic [irpd_pkg::TIME_BITS-1:0] prior_time_next;
    logic                           have_prior_reg;
    logic                           have_prior_next;
    logic [irpd_pkg::TIME_BITS-1:0] gap;
    irpd_pkg::sym_t                 sym;

    assign gap = item.edge_time - prior_time_reg;

    // The zero-bit rule is checked first, as written, even if the thresholds overlap.
    always_comb
    begin
        sym = irpd_pkg::SYM_NONE;
        priority if (!have_prior_reg)
        begin
            sym = irpd_pkg::SYM_NONE;
        end
        else if (gap > zero_floor_reg && gap < one_floor_reg)
        begin
            sym = irpd_pkg::SYM_ZERO;
        end
        else if (gap >= one_floor_reg && gap < one_limit_reg)
        begin
            sym = irpd_pkg::SYM_ONE;
        end
        else
        begin
            sym = irpd_pkg::SYM_NONE;
        end
    end

    assign entry.sym  = sym;
    assign entry.last = item.frame_end;

    always_comb
    begin
        prior_time_next = prior_time_reg;
        have_prior_next = have_prior_reg;
        if (accept)
        begin
            prior_time_next = item.frame_end ? '0 : item.edge_time;
            have_prior_next = !item.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_floor_reg <= irpd_pkg::ZERO_FLOOR_RESET;
            one_floor_reg  <= irpd_pkg::ONE_FLOOR_RESET;
            one_limit_reg  <= irpd_pkg::ONE_LIMIT_RESET;
            prior_time_reg <= '0;
            have_prior_reg <= 1'b0;
        end
        else
        begin
            prior_time_reg <= prior_time_next;
            have_prior_reg <= have_prior_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    irpd_pkg::REG_ZERO_FLOOR: zero_floor_reg <= cfg.data;
                    irpd_pkg::REG_ONE_FLOOR:  one_floor_reg  <= cfg.data;
                    irpd_pkg::REG_ONE_LIMIT:  one_limit_reg  <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[sv/irpd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shifts symbols into the code register and emits one result per frame.
module irpd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 mid_empty,
    input  wire irpd_pkg::mid_entry_t mid_entry,
    output logic                      mid_pop,
    input  wire logic                 res_full,
    output logic                      res_push,
    output irpd_pkg::out_item_t       res_item
);

    logic [irpd_pkg::CODE_BITS-1:0]  code_reg;
    logic [irpd_pkg::CODE_BITS-1:0]  code_next;
    logic [irpd_pkg::COUNT_BITS-1:0] count_reg;
    logic [irpd_pkg::COUNT_BITS-1:0] count_next;
    logic [irpd_pkg::CODE_BITS-1:0]  code_upd;
    logic [irpd_pkg::COUNT_BITS-1:0] count_upd;
    logic                            is_bit;
    logic                            frame_ok;

    // A frame end waits until the result queue has room.
    assign mid_pop  = !mid_empty && (!mid_entry.last || !res_full);
    assign res_push = mid_pop && mid_entry.last;

    always_comb
    begin
        is_bit = 1'b0;
        unique case (mid_entry.sym)
            irpd_pkg::SYM_ZERO: is_bit = 1'b1;
            irpd_pkg::SYM_ONE:  is_bit = 1'b1;
            default:            is_bit = 1'b0;
        endcase
    end

    always_comb
    begin
        code_upd  = code_reg;
        count_upd = count_reg;
        if (is_bit)
        begin
            code_upd = {code_reg[irpd_pkg::CODE_BITS-2:0], mid_entry.sym == irpd_pkg::SYM_ONE};
            if (count_reg != irpd_pkg::COUNT_MAX)
            begin
                count_upd = count_reg + 1'b1;
            end
        end
    end

    assign frame_ok            = (count_upd == irpd_pkg::COUNT_FRAME);
    assign res_item.code_word  = frame_ok ? code_upd : irpd_pkg::BAD_CODE;
    assign res_item.code_valid = frame_ok;
    assign res_item.bits_seen  = count_upd;

    always_comb
    begin
        code_next  = code_reg;
        count_next = count_reg;
        if (mid_pop)
        begin
            code_next  = mid_entry.last ? '0 : code_upd;
            count_next = mid_entry.last ? '0 : count_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            code_reg  <= code_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[sv/ir_pulse_distance_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ir_pulse_distance_decoder_top_defines.svh"

// Pulse-distance infrared frame decoder. Each transfer on the input side carries one edge
// timestamp and a flag that marks the last edge of a frame; the difference to the previous
// timestamp of the frame is classified as a zero bit, a one bit or a non-bit symbol against
// the three threshold registers, and bits are shifted in most significant first. The last
// edge of a frame produces one result holding the code (all ones unless exactly 32 bits were
// seen), a valid flag and the saturating bit count. The block takes one item per clock cycle
// for as long as results are drained: the front end classifies an edge in the cycle of its
// transfer and the back end folds one symbol into the code register per cycle, with a short
// queue between them. The last edge of a frame passes through the symbol queue and then the
// result queue before its result becomes visible, and the result queue holds RES_DEPTH
// results before it pushes back. Thresholds should be written only while no frame is in
// flight; the configuration port never stalls.
module ir_pulse_distance_decoder_top #(
    parameter int MID_DEPTH = irpd_pkg::MID_DEPTH,
    parameter int RES_DEPTH = irpd_pkg::RES_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire irpd_pkg::in_item_t             item,
    output logic                                empty,
    input  wire logic                           pop,
    output irpd_pkg::out_item_t                 result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [irpd_pkg::TIME_BITS-1:0] cfg_data
);

    localparam int MID_W = $bits(irpd_pkg::mid_entry_t);
    localparam int RES_W = $bits(irpd_pkg::out_item_t);

    irpd_pkg::cfg_write_t cfg;
    irpd_pkg::mid_entry_t front_entry;
    irpd_pkg::mid_entry_t back_entry;
    irpd_pkg::out_item_t  back_result;
    logic [MID_W-1:0]     mid_rd_data;
    logic [RES_W-1:0]     res_rd_data;
    logic                 in_accept;
    logic                 mid_empty;
    logic                 mid_pop;
    logic                 res_full;
    logic                 res_push;

    // Register writes complete in the cycle they are presented.
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign in_accept = push && !full;

    irpd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (in_accept),
        .item   (item),
        .entry  (front_entry)
    );

    // Symbol queue between the classifier and the accumulator.
    irpd_queue #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept),
        .wr_data (front_entry),
        .rd_en   (mid_pop),
        .rd_data (mid_rd_data),
        .full    (full),
        .empty   (mid_empty)
    );

    assign back_entry = irpd_pkg::mid_entry_t'(mid_rd_data);

    irpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_entry (back_entry),
        .mid_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (back_result)
    );

    // Result queue; its head is what the result ports show.
    irpd_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_result),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .full    (res_full),
        .empty   (empty)
    );

    assign result = irpd_pkg::out_item_t'(res_rd_data);

    // The back end never offers a result that the result queue would drop.
    `IRPD_ASSERT_SAME(a_res_push_room, clk, rst_n, res_push, !res_full)
    // An accepted edge is waiting in the symbol queue on the following cycle.
    `IRPD_ASSERT_NEXT(a_mid_holds_item, clk, rst_n, in_accept, !mid_empty)
    // A result pushed by the back end is visible on the following cycle.
    `IRPD_ASSERT_NEXT(a_result_visible, clk, rst_n, res_push, !empty)

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the pulse-distance infrared decoder.
//
// Frames of edge timestamps are pushed into the block and every code it returns is compared,
// field by field, against a behavioral decoder kept inside this module. The stimulus starts
// with a few hand-built frames that probe the gap thresholds, timestamp wrap-around and
// single-edge frames. Random frames follow, nearly half well formed: a leader symbol, a run
// of data bits drawn from the current bit windows, and an optional stop symbol. The rest are
// short or noisy frames. The thresholds are rewritten between phases, only while the block
// is idle, and the settings include the register extremes and out-of-order thresholds.
// Both sides of the block idle at random.
module tb_top;
    import irpd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    // Quiet cycles after every owed code has come back, so that the back end settles before
    // a threshold write.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    in_item_t             item      = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    out_item_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [TIME_BITS-1:0] cfg_data  = '0;

    // Threshold registers as the decoder model sees them.
    logic [TIME_BITS-1:0]  zero_floor = ZERO_FLOOR_RESET;
    logic [TIME_BITS-1:0]  one_floor  = ONE_FLOOR_RESET;
    logic [TIME_BITS-1:0]  one_limit  = ONE_LIMIT_RESET;

    // Frame state of the decoder model.
    logic [TIME_BITS-1:0]  last_time  = '0;
    logic                  have_last  = 1'b0;
    logic [CODE_BITS-1:0]  code_shift = '0;
    logic [COUNT_BITS-1:0] bit_count  = '0;

    // Codes that the block still owes, oldest first.
    out_item_t pending_codes[$];

    int fail_count  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    // When clear, neither side idles: this gives stretches of back-to-back transfers.
    bit throttle    = 1'b1;

    ir_pulse_distance_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Decide what a gap means under the current thresholds. The zero-bit rule is tried
    // first, exactly as the hardware does, so out-of-order thresholds behave the same way.
    function automatic sym_t classify_gap(input logic [TIME_BITS-1:0] gap);
        if (gap > zero_floor && gap < one_floor)
            return SYM_ZERO;
        if (gap >= one_floor && gap < one_limit)
            return SYM_ONE;
        return SYM_NONE;
    endfunction

    // Fold one accepted edge into the model. On the last edge of a frame the expected code
    // is queued and the frame state goes back to its reset value.
    function automatic void decode_edge(input in_item_t edge_in);
        logic [TIME_BITS-1:0] gap;
        sym_t                 sym;
        out_item_t            frame_code;
        if (have_last)
        begin
            gap = edge_in.edge_time - last_time;
            sym = classify_gap(gap);
            if (sym != SYM_NONE)
            begin
                code_shift = {code_shift[CODE_BITS-2:0], sym == SYM_ONE};
                if (bit_count != COUNT_MAX)
                    bit_count = bit_count + 1'b1;
            end
        end
        last_time = edge_in.edge_time;
        have_last = 1'b1;
        if (edge_in.frame_end)
        begin
            frame_code.code_valid = (bit_count == COUNT_FRAME);
            frame_code.code_word  = frame_code.code_valid ? code_shift : BAD_CODE;
            frame_code.bits_seen  = bit_count;
            pending_codes.push_back(frame_code);
            last_time  = '0;
            have_last  = 1'b0;
            code_shift = '0;
            bit_count  = '0;
        end
    endfunction

    // Idle length for either side: mostly none, sometimes a few cycles, rarely a long wait.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (!throttle || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // A gap inside the window of the requested bit value, with its ends favored. When the
    // window is empty under the current thresholds any gap will do.
    function automatic logic [TIME_BITS-1:0] pick_bit_gap(input logic bit_one);
        int lo;
        int hi;
        int r;
        if (bit_one)
        begin
            lo = int'(one_floor);
            hi = int'(one_limit) - 1;
        end
        else
        begin
            lo = int'(zero_floor) + 1;
            hi = int'(one_floor) - 1;
        end
        if (lo > hi)
            return TIME_BITS'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)
            return TIME_BITS'(lo);
        if (r == 1)
            return TIME_BITS'(hi);
        return TIME_BITS'($urandom_range(lo, hi));
    endfunction

    // A gap that is no data bit, such as a leader or a stop symbol.
    function automatic logic [TIME_BITS-1:0] pick_symbol_gap();
        logic [TIME_BITS-1:0] cand;
        for (int k = 0; k < 10; k++)
        begin
            case (k)
                6:       cand = zero_floor;
                7:       cand = one_limit;
                8:       cand = '1;
                9:       cand = '0;
                default: cand = TIME_BITS'($urandom);
            endcase
            if (classify_gap(cand) == SYM_NONE)
                return cand;
        end
        return '0;
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_noise_gap();
        if ($urandom_range(0, 1))
            return TIME_BITS'($urandom);
        return TIME_BITS'($urandom_range(0, 80));
    endfunction

    // Offer one edge to the block and hold it until the transfer happens. The push stays
    // high after the transfer so that a following edge can go out in the next cycle.
    task automatic send_edge(input logic [TIME_BITS-1:0] stamp, input logic last);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            @(negedge clk);
            push = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push           = 1'b1;
        item.edge_time = stamp;
        item.frame_end = last;
        do
            @(posedge clk);
        while (full);
        decode_edge(item);
    endtask

    // Send one frame given by its first timestamp and the gaps between its edges.
    task automatic send_frame_gaps(input logic [TIME_BITS-1:0] gaps[$],
                                   input logic [TIME_BITS-1:0] start);
        logic [TIME_BITS-1:0] stamp;
        stamp = start;
        send_edge(stamp, gaps.size() == 0);
        foreach (gaps[i])
        begin
            stamp = stamp + gaps[i];
            send_edge(stamp, i == gaps.size() - 1);
        end
    endtask

    // One random frame. Almost half are well formed, with 32 data bits most of the time;
    // the rest are short frames and frames of mixed bits and noise.
    task automatic send_random_frame(output int sent);
        logic [TIME_BITS-1:0] gaps[$];
        int                   shape;
        int                   nbits;
        shape = $urandom_range(0, 99);
        if (shape < 45)
        begin
            nbits = ($urandom_range(0, 9) < 7) ? 32 : $urandom_range(0, 40);
            gaps.push_back(pick_symbol_gap());
            for (int b = 0; b < nbits; b++)
            begin
                if ($urandom_range(0, 49) == 0)
                    gaps.push_back(pick_noise_gap());
                gaps.push_back(pick_bit_gap($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 1))
                gaps.push_back(pick_symbol_gap());
        end
        else if (shape < 80)
        begin
            repeat ($urandom_range(0, 5)) gaps.push_back(pick_noise_gap());
        end
        else
        begin
            repeat ($urandom_range(0, 40))
            begin
                if ($urandom_range(0, 1))
                    gaps.push_back(pick_bit_gap($urandom_range(0, 1)));
                else
                    gaps.push_back(pick_noise_gap());
            end
        end
        sent = gaps.size() + 1;
        send_frame_gaps(gaps, TIME_BITS'($urandom));
    endtask

    task automatic run_frames(input int edge_budget);
        int edges;
        int sent;
        edges = 0;
        while (edges < edge_budget)
        begin
            throttle = ($urandom_range(0, 3) != 0);
            send_random_frame(sent);
            edges += sent;
        end
    endtask

    // Drop the push, wait until every owed code has come back, then give the back end
    // time to go quiet.
    task automatic wait_idle();
        @(negedge clk);
        push = 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t index, input logic [TIME_BITS-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_ZERO_FLOOR: zero_floor = value;
            REG_ONE_FLOOR:  one_floor  = value;
            REG_ONE_LIMIT:  one_limit  = value;
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_thresholds(input logic [TIME_BITS-1:0] zero_fl,
                                  input logic [TIME_BITS-1:0] one_fl,
                                  input logic [TIME_BITS-1:0] one_lim);
        wait_idle();
        write_reg(REG_ZERO_FLOOR, zero_fl);
        write_reg(REG_ONE_FLOOR, one_fl);
        write_reg(REG_ONE_LIMIT, one_lim);
    endtask

    // Gaps right at and around each threshold of the reset setting. The frame starts just
    // below the top of the timestamp range, so its gaps are taken across the wrap.
    task automatic test_gap_boundaries();
        logic [TIME_BITS-1:0] gaps[$];
        throttle = 1'b1;
        gaps = {16'd0, 16'd1, 16'd12, 16'd13, 16'd27, 16'd28, 16'd54, 16'd55, 16'hffff};
        send_frame_gaps(gaps, 16'hfff0);
    endtask

    // A frame of a single edge holds no gap at all, so no bit can be seen.
    task automatic test_single_edge_frames();
        logic [TIME_BITS-1:0] gaps[$];
        send_frame_gaps(gaps, 16'hffff);
        send_frame_gaps(gaps, 16'h0000);
    endtask

    // Frames with more data bits than the code holds: the code keeps the newest bits and
    // the count stops at its maximum.
    task automatic test_count_saturation();
        logic [TIME_BITS-1:0] gaps[$];
        int                   nbits;
        for (int f = 0; f < 2; f++)
        begin
            throttle = (f == 1);
            nbits    = (f == 0) ? 255 : $urandom_range(256, 270);
            gaps.delete();
            gaps.push_back(pick_symbol_gap());
            repeat (nbits) gaps.push_back(pick_bit_gap($urandom_range(0, 1)));
            send_frame_gaps(gaps, TIME_BITS'($urandom));
        end
    endtask

    task automatic test_default_frames();
        run_frames(80);
    endtask

    // Register extremes and thresholds out of order, where some windows are empty and
    // others swallow gaps of zero or nearly the whole timestamp range.
    task automatic test_threshold_extremes();
        set_thresholds(16'd0, 16'd1, 16'hffff);
        run_frames(40);
        set_thresholds(16'hffff, 16'd0, 16'hffff);
        run_frames(40);
        set_thresholds(16'd0, 16'hffff, 16'hffff);
        run_frames(40);
        set_thresholds(16'd100, 16'd50, 16'd20);
        run_frames(40);
        set_thresholds(16'd20, 16'd10, 16'd40);
        run_frames(40);
    endtask

    // Ordinary threshold sets of random width, then back to the reset setting.
    task automatic test_random_thresholds();
        int zero_fl;
        int one_fl;
        int one_lim;
        repeat (3)
        begin
            zero_fl = $urandom_range(0, 2000);
            one_fl  = zero_fl + $urandom_range(2, 3000);
            one_lim = one_fl + $urandom_range(1, 3000);
            set_thresholds(TIME_BITS'(zero_fl), TIME_BITS'(one_fl), TIME_BITS'(one_lim));
            run_frames(40);
        end
        set_thresholds(ZERO_FLOOR_RESET, ONE_FLOOR_RESET, ONE_LIMIT_RESET);
        run_frames(60);
    endtask

    // Compare one code taken from the block with the oldest one owed.
    task automatic check_code(input out_item_t got);
        out_item_t want;
        if (pending_codes.size() == 0)
        begin
            $error("result with no code owed: code_word %08h bits_seen %0d",
                   got.code_word, got.bits_seen);
            fail_count++;
            return;
        end
        want = pending_codes.pop_front();
        if (got.code_word !== want.code_word)
        begin
            $error("code_word: expected %08h, actual %08h", want.code_word, got.code_word);
            fail_count++;
        end
        if (got.code_valid !== want.code_valid)
        begin
            $error("code_valid: expected %0b, actual %0b", want.code_valid, got.code_valid);
            fail_count++;
        end
        if (got.bits_seen !== want.bits_seen)
        begin
            $error("bits_seen: expected %0d, actual %0d", want.bits_seen, got.bits_seen);
            fail_count++;
        end
    endtask

    // Result side: pop is driven at the falling edge, with random stalls while throttling.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pop = 1'b0;
                stall_left--;
            end
            else
            begin
                pop        = 1'b1;
                stall_left = pick_idle();
            end
        end
    end

    // A result transfer happens at a rising edge with pop high and empty low.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_code(result);
    end

    // Guard against a hang anywhere in the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_gap_boundaries();
        test_single_edge_frames();
        test_count_saturation();
        test_default_frames();
        test_threshold_extremes();
        test_random_thresholds();

        wait_idle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
